/* sv/ethp_pkg.sv */
// shared types and constants of the ethernet/ipv4/tcp header parser
package ethp_pkg;

  localparam int unsigned ETH_HDR_BYTES_DEF = 14;

  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IP   = 8'd0;

  localparam int unsigned OUT_TDATA_W = 152;
  localparam int unsigned OUT_TUSER_W = 4;

  typedef enum logic [2:0] {
    VERD_TCP_OK  = 3'd0,
    VERD_BAD_IP  = 3'd1,
    VERD_UDP     = 3'd2,
    VERD_ICMP    = 3'd3,
    VERD_IP      = 3'd4,
    VERD_UNKNOWN = 3'd5,
    VERD_BAD_TCP = 3'd6,
    VERD_TRUNC   = 3'd7
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] src_tcp_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
    logic        has_payload;
  } result_t;

endpackage

/* sv/ethp_parse_core.sv */
// per-frame header state and byte-by-byte classification logic
module ethp_parse_core
  import ethp_pkg::*;
#(
  parameter int unsigned ETH_HDR_BYTES = ETH_HDR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_valid,
  input  logic [7:0] beat_byte,
  input  logic       beat_start,
  input  logic       beat_end,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [7:0] EthBytes = 8'(ETH_HDR_BYTES);

  logic [7:0]  off_r,   off_nxt;
  logic [3:0]  ihl_r,   ihl_nxt;
  logic [15:0] tlen_r,  tlen_nxt;
  logic [31:0] src_r,   src_nxt;
  logic [31:0] dst_r,   dst_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [31:0] seq_r,   seq_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [3:0]  tw_r,    tw_nxt;
  logic        done_r,  done_nxt;

  logic [7:0]  r;
  logic [5:0]  hl;
  logic [7:0]  t;
  logic        hit;
  verdict_t    verd;
  logic [6:0]  hdr;
  logic [15:0] len;

  always_comb begin
    off_nxt   = off_r;
    ihl_nxt   = ihl_r;
    tlen_nxt  = tlen_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    seq_nxt   = seq_r;
    proto_nxt = proto_r;
    tw_nxt    = tw_r;
    done_nxt  = done_r;
    r         = '0;
    hl        = '0;
    t         = '0;
    hit       = 1'b0;
    verd      = VERD_TRUNC;
    hdr       = '0;
    len       = '0;
    res_valid = 1'b0;
    res       = '0;
    if (beat_valid) begin
      if (beat_start) begin
        off_nxt   = '0;
        ihl_nxt   = '0;
        tlen_nxt  = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
        sport_nxt = '0;
        dport_nxt = '0;
        seq_nxt   = '0;
        proto_nxt = '0;
        tw_nxt    = '0;
        done_nxt  = 1'b0;
      end
      if (!done_nxt) begin
        if (off_nxt >= EthBytes) begin
          r  = off_nxt - EthBytes;
          hl = {ihl_nxt, 2'b00};
          if (r == 8'd0) begin
            ihl_nxt = beat_byte[3:0];
            if (beat_byte[3:0] < MIN_HDR_WORDS) begin
              hit  = 1'b1;
              verd = VERD_BAD_IP;
            end
          end else if (r inside {8'd2, 8'd3}) begin
            tlen_nxt = {tlen_nxt[7:0], beat_byte};
          end else if (r == 8'd9) begin
            proto_nxt = beat_byte;
          end else if (r inside {[8'd12:8'd15]}) begin
            src_nxt = {src_nxt[23:0], beat_byte};
          end else if (r inside {[8'd16:8'd19]}) begin
            dst_nxt = {dst_nxt[23:0], beat_byte};
          end

          // last ip header byte of a non-tcp datagram
          if (!hit && r != 8'd0 && proto_nxt != PROTO_TCP
              && ({1'b0, r} + 9'd1) == {3'b000, hl}) begin
            hit = 1'b1;
            case (proto_nxt)
              PROTO_UDP:  verd = VERD_UDP;
              PROTO_ICMP: verd = VERD_ICMP;
              PROTO_IP:   verd = VERD_IP;
              default:    verd = VERD_UNKNOWN;
            endcase
          end

          if (!hit && r != 8'd0 && proto_nxt == PROTO_TCP && r >= {2'b00, hl}) begin
            t = r - {2'b00, hl};
            if (t <= 8'd1) begin
              sport_nxt = {sport_nxt[7:0], beat_byte};
            end else if (t <= 8'd3) begin
              dport_nxt = {dport_nxt[7:0], beat_byte};
            end else if (t <= 8'd7) begin
              seq_nxt = {seq_nxt[23:0], beat_byte};
            end else if (t == 8'd12) begin
              tw_nxt = beat_byte[7:4];
              if (beat_byte[7:4] < MIN_HDR_WORDS) begin
                hit  = 1'b1;
                verd = VERD_BAD_TCP;
              end
            end
            if (!hit && t > 8'd12 && tw_nxt >= MIN_HDR_WORDS
                && ({1'b0, t} + 9'd1) == {3'b000, tw_nxt, 2'b00}) begin
              hit  = 1'b1;
              verd = VERD_TCP_OK;
            end
          end
        end

        if (!hit && beat_end) begin
          hit  = 1'b1;
          verd = VERD_TRUNC;
        end

        if (off_nxt != 8'hff) begin
          off_nxt = off_nxt + 8'd1;
        end

        if (hit) begin
          done_nxt    = 1'b1;
          res_valid   = 1'b1;
          res.verdict = verd;
          if (verd == VERD_TCP_OK) begin
            hdr = {1'b0, ihl_nxt, 2'b00} + {1'b0, tw_nxt, 2'b00};
            len = (tlen_nxt > {9'd0, hdr}) ? (tlen_nxt - {9'd0, hdr}) : 16'd0;
            res.src_address    = src_nxt;
            res.dst_address    = dst_nxt;
            res.src_tcp_port   = sport_nxt;
            res.dst_port       = dport_nxt;
            res.seq_number     = seq_nxt;
            res.payload_offset = EthBytes + {1'b0, hdr};
            res.payload_length = len;
            res.has_payload    = (len != 16'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r   <= off_nxt;
    ihl_r   <= ihl_nxt;
    tlen_r  <= tlen_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    sport_r <= sport_nxt;
    dport_r <= dport_nxt;
    seq_r   <= seq_nxt;
    proto_r <= proto_nxt;
    tw_r    <= tw_nxt;
  end

endmodule

/* sv/ethp_out_fifo.sv */
// four-entry result buffer feeding the output channel
module ethp_out_fifo
  import ethp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_res,
  input  logic       pop,
  output logic       not_empty,
  output result_t    head,
  output logic [2:0] count
);

  result_t    mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r,  count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + 2'd1) : wr_ptr_r;
    rd_ptr_nxt = pop ? (rd_ptr_r + 2'd1) : rd_ptr_r;
    count_nxt  = count_r + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  assign not_empty = (count_r != 3'd0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

/* sv/eth_ipv4_tcp_header_parser_unit.sv */
// top level of the ethernet/ipv4/tcp header parser
//
// in_*: one captured frame byte per beat, in wire order. in_tdata is the byte,
// in_tuser marks the first byte of a frame, in_tlast the last byte.
// out_*: one beat per classified frame. out_tuser carries the verdict and the
// has-payload flag; out_tdata carries addresses, ports, sequence number,
// payload offset and payload length (all zero unless the verdict is tcp ok).
// a byte is registered, then parsed combinationally against the per-frame header
// state, and a decided verdict lands in a four-entry result buffer: a result
// appears on out_tvalid once the deciding byte has passed the input register and the buffer.
// with the receiver ready, one byte is taken every cycle. in_tready depends
// only on registers: it stays high while the result buffer plus the byte in
// flight hold at most three results, so the input keeps moving while results
// wait; it drops once three results are held with a byte in flight, or four
// are held, until out_tready frees room.
// after reset the parser waits for a byte with in_tuser set; bytes before it,
// and bytes after a frame's verdict, give no result.
module eth_ipv4_tcp_header_parser_unit
  import ethp_pkg::*;
#(
  parameter int unsigned ETH_HDR_BYTES = ETH_HDR_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tuser,   // frame_start
  input  logic                   in_tlast,   // frame_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // src_address, dst_address, src_tcp_port, dst_port,
                                             // seq_number, payload_offset, payload_length
  output logic [OUT_TUSER_W-1:0] out_tuser   // verdict, has_payload
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_end_r;

  logic       in_fire;
  logic       res_valid;
  result_t    res;
  result_t    head;
  logic [2:0] fifo_count;
  logic       out_fire;

  assign in_tready    = ({1'b0, fifo_count} + {3'b000, s1_valid_r}) <= 4'd3;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire;
  assign out_fire     = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
      s1_end_r   <= in_tlast;
    end
  end

  ethp_parse_core #(
    .ETH_HDR_BYTES(ETH_HDR_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_valid(s1_valid_r),
    .beat_byte (s1_byte_r),
    .beat_start(s1_start_r),
    .beat_end  (s1_end_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ethp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_res (res),
    .pop      (out_fire),
    .not_empty(out_tvalid),
    .head     (head),
    .count    (fifo_count)
  );

  assign out_tdata = {head.payload_length, head.payload_offset, head.seq_number,
                      head.dst_port, head.src_tcp_port, head.dst_address, head.src_address};
  assign out_tuser = {head.has_payload, head.verdict};

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> fifo_count != 3'd4)
    else $error("result pushed into full buffer");

  a_res_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> s1_valid_r)
    else $error("result without a byte in flight");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= 3'd4)
    else $error("result buffer count out of range");

  a_ready_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && s1_valid_r) |-> fifo_count <= 3'd2)
    else $error("input taken without room for its result");
`endif

endmodule
